// ===== design/mfrq_pkg.sv =====
package mfrq_pkg;

    // table sizes; the port widths are built for exactly these
    localparam int SLOTS      = 8;
    localparam int CONSUMERS  = 4;
    localparam int RING_DEPTH = 32;
    localparam int HANDLES    = 256;

    localparam logic [2:0] KIND_REGISTER = 3'd0;
    localparam logic [2:0] KIND_ATTACH   = 3'd1;
    localparam logic [2:0] KIND_DETACH   = 3'd2;
    localparam logic [2:0] KIND_PUT      = 3'd3;
    localparam logic [2:0] KIND_TAKE     = 3'd4;
    localparam logic [2:0] KIND_RELEASE  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [1:0] REG_STREAMS = 2'd0;
    localparam logic [1:0] REG_ENABLE  = 2'd1;

    // one request as it travels from the front to the back
    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] stream_key;
        logic [2:0]  slot_index;
        logic [1:0]  consumer_index;
        logic [7:0]  frame_handle;
        logic        reject;
    } mfrq_req_t;

endpackage

// ===== design/mfrq_front.sv =====
module mfrq_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [2:0]            kind,
    input  logic [47:0]           stream_key,
    input  logic [2:0]            slot_index,
    input  logic [1:0]            consumer_index,
    input  logic [7:0]            frame_handle,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [3:0]            cfg_data,
    output logic                  req_valid,
    output mfrq_pkg::mfrq_req_t   req,
    output logic [3:0]            streams_reg
);

    logic enable_reg;
    logic reject;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streams_reg <= 4'd8;
            enable_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mfrq_pkg::REG_STREAMS)
                streams_reg <= cfg_data;
            else if (cfg_index == mfrq_pkg::REG_ENABLE)
                enable_reg <= cfg_data[0];
        end
    end

    // classify: disabled or unknown kind is rejected outright
    assign reject = !enable_reg || (kind > mfrq_pkg::KIND_RELEASE);

    assign req_valid = start && !busy;
    assign req = '{kind: kind, stream_key: stream_key, slot_index: slot_index,
                   consumer_index: consumer_index, frame_handle: frame_handle,
                   reject: reject};

endmodule

// ===== design/mfrq_back.sv =====
module mfrq_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  mfrq_pkg::mfrq_req_t   req,
    input  logic [3:0]            streams_reg,
    output logic                  req_ready,
    output logic                  res_valid,
    output logic [1:0]            status,
    output logic [2:0]            slot_out,
    output logic [1:0]            consumer_out,
    output logic [7:0]            frame_out,
    output logic [3:0]            delivered_mask,
    output logic                  freed,
    output logic                  last
);

    localparam int SLOTS      = mfrq_pkg::SLOTS;
    localparam int CONSUMERS  = mfrq_pkg::CONSUMERS;
    localparam int RING_DEPTH = mfrq_pkg::RING_DEPTH;
    localparam int HANDLES    = mfrq_pkg::HANDLES;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;
    localparam int PW = $clog2(RING_DEPTH);
    localparam int HW = (HANDLES > 1) ? $clog2(HANDLES) : 1;
    localparam int RINGS = SLOTS * CONSUMERS;
    localparam int RW = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int CNTW = $clog2(CONSUMERS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_RDREQ = 3'd3;
    localparam logic [2:0] S_RDDAT = 3'd4;
    localparam logic [2:0] S_REL   = 3'd5;
    localparam logic [2:0] S_TRD   = 3'd6;
    localparam logic [2:0] S_DRAIN = 3'd7;

    // one-entry request queue
    logic                q_full_reg;
    mfrq_pkg::mfrq_req_t q_reg;
    mfrq_pkg::mfrq_req_t cur_reg;
    logic [2:0]          state_reg;

    logic                  slot_used_reg [SLOTS];
    logic [47:0]           slot_key_reg  [SLOTS];
    logic                  active_reg    [RINGS];
    logic [PW-1:0]         head_reg      [RINGS];
    logic [PW-1:0]         tail_reg      [RINGS];
    logic [7:0]            ring_mem [RINGS*RING_DEPTH];
    logic [CNTW-1:0]       rc_mem   [HANDLES];
    logic                  rc_valid_reg [HANDLES];
    logic [7:0]            ring_rd_reg;
    logic [CNTW-1:0]       rc_rd_reg;
    logic                  rc_rdv_reg;

    logic [CW-1:0]         c_reg;
    logic [3:0]            mask_reg;
    logic [CNTW-1:0]       copies_reg;
    logic [7:0]            handle_reg;
    logic [RW-1:0]         ring_sel_reg;

    // effective slot count
    logic [6:0] n_eff;
    assign n_eff = ({3'd0, streams_reg} < 7'(SLOTS)) ? {3'd0, streams_reg} : 7'(SLOTS);

    // request queue
    assign req_ready = !q_full_reg;
    logic pop;
    assign pop = q_full_reg && (state_reg == S_IDLE);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_full_reg <= 1'b0;
        else if (req_valid && !q_full_reg)
            q_full_reg <= 1'b1;
        else if (pop)
            q_full_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (req_valid && !q_full_reg)
            q_reg <= req;
        if (pop)
            cur_reg <= q_reg;
    end

    // slot searches over the small slot table
    logic [SW-1:0] reg_slot, att_slot;
    logic          reg_hit, att_hit;
    always_comb
    begin
        reg_hit = 1'b0;
        att_hit = 1'b0;
        reg_slot = '0;
        att_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (7'(i) < n_eff)
            begin
                if (!slot_used_reg[i] || slot_key_reg[i] == cur_reg.stream_key)
                begin
                    reg_hit = 1'b1;
                    reg_slot = SW'(i);
                end
                if (slot_used_reg[i] && slot_key_reg[i] == cur_reg.stream_key)
                begin
                    att_hit = 1'b1;
                    att_slot = SW'(i);
                end
            end
        end
    end

    // first free consumer of the attach slot
    logic [CW-1:0] free_c;
    logic          free_hit;
    always_comb
    begin
        free_hit = 1'b0;
        free_c = '0;
        for (int c = CONSUMERS - 1; c >= 0; c--)
        begin
            if (!active_reg[int'(att_slot) * CONSUMERS + c])
            begin
                free_hit = 1'b1;
                free_c = CW'(c);
            end
        end
    end

    logic [SW-1:0] cs;
    logic          slot_ok, cons_ok, key_ok, h_ok;
    logic [RW-1:0] cur_ring, put_ring;
    assign cs       = cur_reg.slot_index[SW-1:0];
    assign slot_ok  = {4'd0, cur_reg.slot_index} < n_eff;
    assign cons_ok  = {1'b0, cur_reg.consumer_index} < 3'(CONSUMERS);
    assign key_ok   = slot_key_reg[cs] == cur_reg.stream_key;
    assign h_ok     = {1'b0, cur_reg.frame_handle} < 9'(HANDLES);
    assign cur_ring = RW'(int'(cs) * CONSUMERS + int'(cur_reg.consumer_index[CW-1:0]));
    assign put_ring = RW'(int'(cs) * CONSUMERS + int'(c_reg));

    logic [HW-1:0] hidx;
    assign hidx = handle_reg[HW-1:0];
    logic [CNTW-1:0] rc_eff;
    assign rc_eff = rc_rdv_reg ? rc_rd_reg : '0;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid <= 1'b0;
            status <= '0;
            slot_out <= '0;
            consumer_out <= '0;
            frame_out <= '0;
            delivered_mask <= '0;
            freed <= 1'b0;
            last <= 1'b0;
            c_reg <= '0;
            mask_reg <= '0;
            copies_reg <= '0;
            handle_reg <= '0;
            ring_sel_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used_reg[i] <= 1'b0;
                slot_key_reg[i]  <= '0;
            end
            for (int r = 0; r < RINGS; r++)
            begin
                active_reg[r] <= 1'b0;
                head_reg[r]   <= '0;
                tail_reg[r]   <= '0;
            end
            for (int h = 0; h < HANDLES; h++)
                rc_valid_reg[h] <= 1'b0;
        end
        else
        begin
            res_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    status <= mfrq_pkg::ST_REJECT;
                    slot_out <= '0;
                    consumer_out <= '0;
                    frame_out <= '0;
                    delivered_mask <= '0;
                    freed <= 1'b0;
                    last <= 1'b1;
                    c_reg <= '0;
                    mask_reg <= '0;
                    copies_reg <= '0;
                    handle_reg <= cur_reg.frame_handle;
                    ring_sel_reg <= cur_ring;
                    state_reg <= S_IDLE;
                    res_valid <= 1'b1;
                    if (!cur_reg.reject)
                    begin
                        case (cur_reg.kind)
                            mfrq_pkg::KIND_REGISTER:
                            begin
                                if (reg_hit)
                                begin
                                    slot_used_reg[reg_slot] <= 1'b1;
                                    slot_key_reg[reg_slot] <= cur_reg.stream_key;
                                    status <= mfrq_pkg::ST_OK;
                                    slot_out <= 3'(reg_slot);
                                end
                            end
                            mfrq_pkg::KIND_ATTACH:
                            begin
                                if (att_hit && free_hit)
                                begin
                                    active_reg[int'(att_slot) * CONSUMERS + int'(free_c)] <= 1'b1;
                                    head_reg[int'(att_slot) * CONSUMERS + int'(free_c)] <= '0;
                                    tail_reg[int'(att_slot) * CONSUMERS + int'(free_c)] <= '0;
                                    status <= mfrq_pkg::ST_OK;
                                    slot_out <= 3'(att_slot);
                                    consumer_out <= 2'(free_c);
                                end
                            end
                            mfrq_pkg::KIND_DETACH:
                            begin
                                if (slot_ok && slot_used_reg[cs] && key_ok && cons_ok
                                    && active_reg[cur_ring])
                                begin
                                    if (head_reg[cur_ring] == tail_reg[cur_ring])
                                    begin
                                        status <= mfrq_pkg::ST_OK;
                                        active_reg[cur_ring] <= 1'b0;
                                        head_reg[cur_ring] <= '0;
                                        tail_reg[cur_ring] <= '0;
                                    end
                                    else
                                    begin
                                        res_valid <= 1'b0;
                                        state_reg <= S_RDREQ;
                                    end
                                end
                            end
                            mfrq_pkg::KIND_PUT:
                            begin
                                if (slot_ok && key_ok && h_ok)
                                begin
                                    res_valid <= 1'b0;
                                    state_reg <= S_PUT;
                                end
                            end
                            mfrq_pkg::KIND_TAKE:
                            begin
                                if (slot_ok && cons_ok && active_reg[cur_ring])
                                begin
                                    if (head_reg[cur_ring] == tail_reg[cur_ring])
                                        status <= mfrq_pkg::ST_EMPTY;
                                    else
                                    begin
                                        res_valid <= 1'b0;
                                        state_reg <= S_TRD;
                                    end
                                end
                            end
                            mfrq_pkg::KIND_RELEASE:
                            begin
                                if (slot_ok && key_ok && h_ok)
                                begin
                                    res_valid <= 1'b0;
                                    state_reg <= S_REL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                // one consumer ring per cycle
                S_PUT:
                begin
                    if (active_reg[put_ring]
                        && PW'(tail_reg[put_ring] + 1'b1) != head_reg[put_ring])
                    begin
                        tail_reg[put_ring] <= PW'(tail_reg[put_ring] + 1'b1);
                        mask_reg[c_reg] <= 1'b1;
                        copies_reg <= copies_reg + 1'b1;
                    end
                    if (int'(c_reg) == CONSUMERS - 1)
                        state_reg <= S_IDLE;
                    else
                        c_reg <= c_reg + 1'b1;
                    if (int'(c_reg) == CONSUMERS - 1)
                    begin
                        res_valid <= 1'b1;
                        status <= mfrq_pkg::ST_OK;
                        if (active_reg[put_ring]
                            && PW'(tail_reg[put_ring] + 1'b1) != head_reg[put_ring])
                        begin
                            rc_valid_reg[hidx] <= 1'b1;
                            delivered_mask <= mask_reg | (4'd1 << c_reg);
                        end
                        else if (copies_reg == '0)
                        begin
                            rc_valid_reg[hidx] <= 1'b1;
                            frame_out <= handle_reg;
                            freed <= 1'b1;
                        end
                        else
                        begin
                            rc_valid_reg[hidx] <= 1'b1;
                            delivered_mask <= mask_reg;
                        end
                    end
                end
                // release: count read issued in S_EXEC cycle, data ready now
                S_REL:
                begin
                    res_valid <= 1'b1;
                    state_reg <= S_IDLE;
                    if (rc_eff != '0)
                    begin
                        status <= mfrq_pkg::ST_OK;
                        if (rc_eff == CNTW'(1))
                        begin
                            frame_out <= handle_reg;
                            freed <= 1'b1;
                        end
                    end
                end
                S_TRD:
                begin
                    state_reg <= S_RDDAT;
                end
                // detach drain: issue ring read
                S_RDREQ:
                begin
                    state_reg <= S_RDDAT;
                end
                // ring data is here; its count read is issued now and returns in S_DRAIN
                S_RDDAT:
                begin
                    handle_reg <= ring_rd_reg;
                    if (cur_reg.kind == mfrq_pkg::KIND_TAKE)
                    begin
                        head_reg[ring_sel_reg] <= PW'(head_reg[ring_sel_reg] + 1'b1);
                        status <= mfrq_pkg::ST_OK;
                        frame_out <= ring_rd_reg;
                        res_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_DRAIN;
                end
                // drain step: count data valid
                S_DRAIN:
                begin
                    res_valid <= 1'b1;
                    status <= mfrq_pkg::ST_OK;
                    frame_out <= handle_reg;
                    freed <= (rc_eff == CNTW'(1)) && (32'(handle_reg) < HANDLES);
                    if (PW'(head_reg[ring_sel_reg] + 1'b1) == tail_reg[ring_sel_reg])
                    begin
                        last <= 1'b1;
                        active_reg[ring_sel_reg] <= 1'b0;
                        head_reg[ring_sel_reg] <= '0;
                        tail_reg[ring_sel_reg] <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        head_reg[ring_sel_reg] <= PW'(head_reg[ring_sel_reg] + 1'b1);
                        last <= 1'b0;
                        state_reg <= S_RDREQ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ring entry memory: write on put, read at the ring head
    logic [RW+PW-1:0] ring_waddr, ring_raddr;
    assign ring_waddr = {put_ring, tail_reg[put_ring]};
    assign ring_raddr = {ring_sel_reg, head_reg[ring_sel_reg]};
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PUT && active_reg[put_ring]
            && PW'(tail_reg[put_ring] + 1'b1) != head_reg[put_ring])
            ring_mem[ring_waddr] <= handle_reg;
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    // reference count memory, read address is the current handle (in S_RDDAT the ring entry just read)
    logic          rc_we;
    logic [CNTW-1:0] rc_wdata;
    logic [HW-1:0] rc_raddr;
    always_comb
    begin
        rc_we = 1'b0;
        rc_wdata = '0;
        if (state_reg == S_PUT && int'(c_reg) == CONSUMERS - 1)
        begin
            rc_we = 1'b1;
            rc_wdata = copies_reg + CNTW'(active_reg[put_ring]
                && PW'(tail_reg[put_ring] + 1'b1) != head_reg[put_ring]);
        end
        else if (state_reg == S_REL && rc_eff != '0)
        begin
            rc_we = 1'b1;
            rc_wdata = rc_eff - 1'b1;
        end
        else if (state_reg == S_DRAIN && rc_eff != '0 && 32'(handle_reg) < HANDLES)
        begin
            rc_we = 1'b1;
            rc_wdata = rc_eff - 1'b1;
        end
    end
    assign rc_raddr = (state_reg == S_RDDAT) ? ring_rd_reg[HW-1:0]
                                             : cur_reg.frame_handle[HW-1:0];
    always_ff @(posedge clk)
    begin
        if (rc_we)
            rc_mem[hidx] <= rc_wdata;
        rc_rd_reg <= rc_mem[rc_raddr];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rc_rdv_reg <= 1'b0;
        else
            rc_rdv_reg <= rc_valid_reg[rc_raddr];
    end

`ifndef NO_ASSERTIONS
    // a put never counts more copies than consumers
    a_copies: assert property (@(posedge clk) disable iff (!rst_n)
        copies_reg <= CNTW'(CONSUMERS)) else $error("copy count overflow");
    // freed results always carry ok status
    a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && freed |-> status == mfrq_pkg::ST_OK) else $error("freed without ok");
    // the queue is only popped while the sequencer is idle
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_EXEC) else $error("pop lost");
`endif

endmodule

// ===== design/multicast_frame_ring_queue_top.sv =====
// Multicast frame ring queue. Requests enter on start while busy is low;
// each request produces one or more results, each shown for one cycle with
// done high and last marking the final one. The receiver cannot stall.
// Register, attach, rejected requests, an empty take and an empty detach
// answer straight from the execute state; release first reads the
// reference count; take reads through the registered ring memory; put
// walks the consumer rings one per cycle; detach gives one result per
// drained entry, reading each entry and then its count. busy is high from
// acceptance through the cycle of the request's last result, so the next
// request can be taken in the cycle after it. No clearing pass.
module multicast_frame_ring_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [47:0] stream_key,
    input  logic [2:0]  slot_index,
    input  logic [1:0]  consumer_index,
    input  logic [7:0]  frame_handle,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  slot_out,
    output logic [1:0]  consumer_out,
    output logic [7:0]  frame_out,
    output logic [3:0]  delivered_mask,
    output logic        freed,
    output logic        last
);

    logic                req_valid, req_ready;
    mfrq_pkg::mfrq_req_t req;
    logic [3:0]          streams;
    logic                busy_reg;

    // busy from acceptance until the last result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (req_valid)
            busy_reg <= 1'b1;
        else if (done && last)
            busy_reg <= 1'b0;
    end
    assign busy = busy_reg || !req_ready;

    mfrq_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .stream_key(stream_key), .slot_index(slot_index),
        .consumer_index(consumer_index), .frame_handle(frame_handle),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req(req), .streams_reg(streams)
    );

    mfrq_back u_back (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req(req),
        .streams_reg(streams), .req_ready(req_ready), .res_valid(done),
        .status(status), .slot_out(slot_out), .consumer_out(consumer_out),
        .frame_out(frame_out), .delivered_mask(delivered_mask),
        .freed(freed), .last(last)
    );

endmodule

// ===== bench/mfrq_checker.sv =====
module mfrq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  kind,
    input  logic [47:0] stream_key,
    input  logic [2:0]  slot_index,
    input  logic [1:0]  consumer_index,
    input  logic [7:0]  frame_handle,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [2:0]  slot_out,
    input  logic [1:0]  consumer_out,
    input  logic [7:0]  frame_out,
    input  logic [3:0]  delivered_mask,
    input  logic        freed,
    input  logic        last,
    output int          error_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 8;
    localparam int NCONS = 4;
    localparam int DEPTH = 32;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
        logic [1:0] cons;
        logic [7:0] frame;
        logic [3:0] mask;
        logic       freed;
        logic       last;
    } queue_result_t;

    // shadow copy of the queue state
    logic        slot_used   [NSLOT];
    logic [47:0] slot_key    [NSLOT];
    logic        cons_active [NSLOT*NCONS];
    logic [4:0]  ring_rd     [NSLOT*NCONS];
    logic [4:0]  ring_wr     [NSLOT*NCONS];
    logic [7:0]  ring_mem    [NSLOT*NCONS*DEPTH];
    logic [2:0]  ref_cnt     [256];
    logic [3:0]  streams_cfg;
    logic        enable_cfg;

    queue_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic queue_result_t mk_result(logic [1:0] st, logic [2:0] sl, logic [1:0] co,
                                                logic [7:0] fr, logic [3:0] dm, logic fd,
                                                logic la);
        queue_result_t r;
        r = '{st, sl, co, fr, dm, fd, la};
        return r;
    endfunction

    // compute the results of one accepted request and update the shadow state
    task automatic predict_request(logic [2:0] k, logic [47:0] key, logic [2:0] s,
                                   logic [1:0] c, logic [7:0] h);
        int n;
        int i;
        int r;
        int copies;
        logic [3:0] mask;
        logic [7:0] e;
        logic fd;
        queue_result_t reject;
        n = (streams_cfg < NSLOT) ? streams_cfg : NSLOT;
        reject = mk_result(mfrq_pkg::ST_REJECT, 3'd0, 2'd0, 8'd0, 4'd0, 1'b0, 1'b1);
        if (!enable_cfg || k > mfrq_pkg::KIND_RELEASE) begin
            expected_results.push_back(reject);
            return;
        end
        case (k)
            mfrq_pkg::KIND_REGISTER: begin
                for (i = 0; i < n; i++)
                    if (!slot_used[i] || slot_key[i] == key) break;
                if (i >= n) begin
                    expected_results.push_back(reject);
                end else begin
                    slot_key[i] = key;
                    slot_used[i] = 1'b1;
                    expected_results.push_back(
                        mk_result(mfrq_pkg::ST_OK, 3'(i), 2'd0, 8'd0, 4'd0, 1'b0, 1'b1));
                end
            end
            mfrq_pkg::KIND_ATTACH: begin
                for (i = 0; i < n; i++)
                    if (slot_used[i] && slot_key[i] == key) break;
                if (i >= n) begin
                    expected_results.push_back(reject);
                end else begin
                    for (r = 0; r < NCONS; r++)
                        if (!cons_active[i*NCONS+r]) break;
                    if (r >= NCONS) begin
                        expected_results.push_back(reject);
                    end else begin
                        cons_active[i*NCONS+r] = 1'b1;
                        ring_rd[i*NCONS+r] = '0;
                        ring_wr[i*NCONS+r] = '0;
                        expected_results.push_back(
                            mk_result(mfrq_pkg::ST_OK, 3'(i), 2'(r), 8'd0, 4'd0, 1'b0, 1'b1));
                    end
                end
            end
            default: begin
                r = s*NCONS + c;
                if (s >= n) begin
                    expected_results.push_back(reject);
                end else if (k == mfrq_pkg::KIND_DETACH) begin
                    if (!slot_used[s] || slot_key[s] != key || !cons_active[r]) begin
                        expected_results.push_back(reject);
                    end else begin
                        if (ring_rd[r] == ring_wr[r])
                            expected_results.push_back(
                                mk_result(mfrq_pkg::ST_OK, 3'd0, 2'd0, 8'd0, 4'd0, 1'b0, 1'b1));
                        // drain: one result per entry
                        while (ring_rd[r] != ring_wr[r]) begin
                            e = ring_mem[r*DEPTH + ring_rd[r]];
                            fd = 1'b0;
                            if (ref_cnt[e] != 3'd0) begin
                                ref_cnt[e] = ref_cnt[e] - 3'd1;
                                fd = (ref_cnt[e] == 3'd0);
                            end
                            ring_rd[r] = ring_rd[r] + 5'd1;
                            expected_results.push_back(
                                mk_result(mfrq_pkg::ST_OK, 3'd0, 2'd0, e, 4'd0, fd,
                                          ring_rd[r] == ring_wr[r]));
                        end
                        cons_active[r] = 1'b0;
                        ring_rd[r] = '0;
                        ring_wr[r] = '0;
                    end
                end else if (k == mfrq_pkg::KIND_PUT) begin
                    if (slot_key[s] != key) begin
                        expected_results.push_back(reject);
                    end else begin
                        mask = '0;
                        copies = 0;
                        for (i = 0; i < NCONS; i++) begin
                            r = s*NCONS + i;
                            if (cons_active[r] && 5'(ring_wr[r] + 5'd1) != ring_rd[r]) begin
                                ring_mem[r*DEPTH + ring_wr[r]] = h;
                                ring_wr[r] = ring_wr[r] + 5'd1;
                                mask[i] = 1'b1;
                                copies++;
                            end
                        end
                        ref_cnt[h] = 3'(copies);
                        if (copies == 0)
                            expected_results.push_back(
                                mk_result(mfrq_pkg::ST_OK, 3'd0, 2'd0, h, 4'd0, 1'b1, 1'b1));
                        else
                            expected_results.push_back(
                                mk_result(mfrq_pkg::ST_OK, 3'd0, 2'd0, 8'd0, mask, 1'b0, 1'b1));
                    end
                end else if (k == mfrq_pkg::KIND_TAKE) begin
                    if (!cons_active[r]) begin
                        expected_results.push_back(reject);
                    end else if (ring_rd[r] == ring_wr[r]) begin
                        expected_results.push_back(
                            mk_result(mfrq_pkg::ST_EMPTY, 3'd0, 2'd0, 8'd0, 4'd0, 1'b0, 1'b1));
                    end else begin
                        e = ring_mem[r*DEPTH + ring_rd[r]];
                        ring_rd[r] = ring_rd[r] + 5'd1;
                        expected_results.push_back(
                            mk_result(mfrq_pkg::ST_OK, 3'd0, 2'd0, e, 4'd0, 1'b0, 1'b1));
                    end
                end else begin
                    // release
                    if (slot_key[s] != key || ref_cnt[h] == 3'd0) begin
                        expected_results.push_back(reject);
                    end else begin
                        ref_cnt[h] = ref_cnt[h] - 3'd1;
                        if (ref_cnt[h] == 3'd0)
                            expected_results.push_back(
                                mk_result(mfrq_pkg::ST_OK, 3'd0, 2'd0, h, 4'd0, 1'b1, 1'b1));
                        else
                            expected_results.push_back(
                                mk_result(mfrq_pkg::ST_OK, 3'd0, 2'd0, 8'd0, 4'd0, 1'b0, 1'b1));
                    end
                end
            end
        endcase
    endtask

    function automatic int field_errors(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        queue_result_t exp_r;
        int errs;
        if (!rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i] = '0;
            end
            for (int i = 0; i < NSLOT*NCONS; i++) begin
                cons_active[i] = 1'b0;
                ring_rd[i] = '0;
                ring_wr[i] = '0;
            end
            for (int i = 0; i < NSLOT*NCONS*DEPTH; i++) ring_mem[i] = '0;
            for (int i = 0; i < 256; i++) ref_cnt[i] = '0;
            streams_cfg = 4'd8;
            enable_cfg = 1'b1;
            expected_results.delete();
            error_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == mfrq_pkg::REG_STREAMS) streams_cfg = cfg_data;
                else if (cfg_index == mfrq_pkg::REG_ENABLE) enable_cfg = cfg_data[0];
            end
            if (start && !busy)
                predict_request(kind, stream_key, slot_index, consumer_index, frame_handle);
            if (done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    errs = field_errors("status", exp_r.status, status)
                         + field_errors("slot_out", exp_r.slot, slot_out)
                         + field_errors("consumer_out", exp_r.cons, consumer_out)
                         + field_errors("frame_out", exp_r.frame, frame_out)
                         + field_errors("delivered_mask", exp_r.mask, delivered_mask)
                         + field_errors("freed", exp_r.freed, freed)
                         + field_errors("last", exp_r.last, last);
                    error_count += errs;
                end
            end
        end
    end

endmodule

// ===== bench/tb_multicast_frame_ring_queue_top.sv =====
module tb_multicast_frame_ring_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  kind = '0;
    logic [47:0] stream_key = '0;
    logic [2:0]  slot_index = '0;
    logic [1:0]  consumer_index = '0;
    logic [7:0]  frame_handle = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  slot_out;
    logic [1:0]  consumer_out;
    logic [7:0]  frame_out;
    logic [3:0]  delivered_mask;
    logic        freed;
    logic        last;
    int          error_count;
    int          pending;
    int          stall_cycles = 0;
    int          burst_left = 0;
    logic [47:0] stream_keys [8];

    multicast_frame_ring_queue_top dut (.*);

    mfrq_checker checker_i (.*);

    initial begin
        forever #1 clk = ~clk;
    end

    // watchdog: cycles with no request accepted and no result seen
    always @(posedge clk) begin
        if ((start && !busy) || done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // present one request and hold it until accepted; start stays high
    task automatic send(logic [2:0] k, logic [47:0] key, logic [2:0] s,
                        logic [1:0] c, logic [7:0] h);
        start <= 1'b1;
        kind <= k;
        stream_key <= key;
        slot_index <= s;
        consumer_index <= c;
        frame_handle <= h;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // bursty sender: random gaps between bursts, some long runs with none
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain_all();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        drain_all();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        int pick;
        int s;
        logic [2:0] k;
        logic [47:0] key;
        logic [7:0] h;
        pick = $urandom_range(0, 99);
        s = $urandom_range(0, 7);
        if (pick < 5) k = mfrq_pkg::KIND_REGISTER;
        else if (pick < 19) k = mfrq_pkg::KIND_ATTACH;
        else if (pick < 27) k = mfrq_pkg::KIND_DETACH;
        else if (pick < 60) k = mfrq_pkg::KIND_PUT;
        else if (pick < 82) k = mfrq_pkg::KIND_TAKE;
        else if (pick < 96) k = mfrq_pkg::KIND_RELEASE;
        else k = 3'($urandom_range(6, 7));
        pick = $urandom_range(0, 19);
        if (k == mfrq_pkg::KIND_REGISTER || k == mfrq_pkg::KIND_ATTACH)
            key = stream_keys[$urandom_range(0, 7)];
        else if (pick < 17) key = stream_keys[s];
        else if (pick < 19) key = stream_keys[$urandom_range(0, 7)];
        else key = {16'($urandom), $urandom};
        if (k == mfrq_pkg::KIND_REGISTER && pick == 0) key = {16'($urandom), $urandom};
        h = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        send(k, key, 3'(s), 2'($urandom_range(0, 3)), h);
        pace();
    endtask

    initial begin
        stream_keys[0] = '0;
        stream_keys[7] = '1;
        for (int i = 1; i < 7; i++) stream_keys[i] = {16'($urandom), $urandom};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests
        send(mfrq_pkg::KIND_PUT, '0, 3'd1, 2'd0, 8'd0);   // unused slot with reset key
        send(3'd6, '1, 3'd7, 2'd3, 8'hff);
        send(3'd7, '0, 3'd0, 2'd0, 8'd0);
        send(mfrq_pkg::KIND_TAKE, '0, 3'd0, 2'd0, 8'd0);  // inactive consumer
        for (int i = 0; i < 8; i++)
            send(mfrq_pkg::KIND_REGISTER, stream_keys[i], 3'd0, 2'd0, 8'd0);
        send(mfrq_pkg::KIND_REGISTER, 48'h5a5a_a5a5_1234, 3'd0, 2'd0, 8'd0);  // table full
        send(mfrq_pkg::KIND_ATTACH, stream_keys[0], 3'd0, 2'd0, 8'd0);
        send(mfrq_pkg::KIND_ATTACH, stream_keys[0], 3'd0, 2'd0, 8'd0);
        send(mfrq_pkg::KIND_ATTACH, 48'h1, 3'd0, 2'd0, 8'd0);          // unknown key
        send(mfrq_pkg::KIND_PUT, stream_keys[0], 3'd0, 2'd0, 8'hff);
        send(mfrq_pkg::KIND_PUT, stream_keys[7], 3'd0, 2'd0, 8'h80);   // key mismatch
        send(mfrq_pkg::KIND_TAKE, stream_keys[0], 3'd0, 2'd0, 8'd0);
        send(mfrq_pkg::KIND_TAKE, stream_keys[0], 3'd0, 2'd0, 8'd0);   // ring empty
        send(mfrq_pkg::KIND_RELEASE, stream_keys[0], 3'd0, 2'd0, 8'hff);
        send(mfrq_pkg::KIND_RELEASE, stream_keys[0], 3'd0, 2'd0, 8'hff);  // count hits zero
        send(mfrq_pkg::KIND_RELEASE, stream_keys[0], 3'd0, 2'd0, 8'hff);  // already zero
        send(mfrq_pkg::KIND_DETACH, stream_keys[0], 3'd0, 2'd1, 8'd0);    // drain at zero
        send(mfrq_pkg::KIND_DETACH, stream_keys[0], 3'd0, 2'd1, 8'd0);    // now inactive
        send(mfrq_pkg::KIND_DETACH, stream_keys[0], 3'd0, 2'd0, 8'd0);    // empty ring

        // fill one ring past full, then drain it in one detach
        send(mfrq_pkg::KIND_ATTACH, stream_keys[2], 3'd0, 2'd0, 8'd0);
        for (int i = 0; i < 33; i++) begin
            send(mfrq_pkg::KIND_PUT, stream_keys[2], 3'd2, 2'd0, 8'($urandom));
            pace();
        end
        send(mfrq_pkg::KIND_DETACH, stream_keys[2], 3'd2, 2'd0, 8'd0);

        for (int i = 0; i < 130; i++) random_request();
        write_reg(mfrq_pkg::REG_STREAMS, 4'd1);
        for (int i = 0; i < 35; i++) random_request();
        write_reg(mfrq_pkg::REG_ENABLE, 4'd0);
        for (int i = 0; i < 12; i++) random_request();
        write_reg(mfrq_pkg::REG_ENABLE, 4'd1);
        write_reg(mfrq_pkg::REG_STREAMS, 4'd15);
        for (int i = 0; i < 60; i++) random_request();
        write_reg(mfrq_pkg::REG_STREAMS, 4'd5);
        for (int i = 0; i < 60; i++) random_request();

        drain_all();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
